### rtl/apc_pkg.sv
// shared types and constants for the anaglyph pixel combiner
// depends on nothing; imported by apc_eye and anaglyph_pixel_combine
package apc_pkg;

  // intensity of one pixel is b + 2r + 4g, at most 1785
  localparam int unsigned IntensityW = 11;
  localparam int unsigned ProdW      = 19;
  localparam int unsigned RecipW     = 20;
  localparam int unsigned DivShift   = 30;

  localparam logic [IntensityW-1:0] MAX_INTENSITY = 11'd1785;
  localparam logic [7:0]            FULL_LEVEL    = 8'd255;

  // ceil(2^30 / 1786): exact floor division for every product below 2^19
  localparam logic [RecipW-1:0]     RECIP_1786    = 20'd601200;

  // output channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // register indexes on the config port
  localparam logic [2:0] REG_LEFT_CHANNEL  = 3'd0;
  localparam logic [2:0] REG_RIGHT_CHANNEL = 3'd1;
  localparam logic [2:0] REG_LEFT_BOTTOM   = 3'd2;
  localparam logic [2:0] REG_LEFT_TOP      = 3'd3;
  localparam logic [2:0] REG_RIGHT_BOTTOM  = 3'd4;
  localparam logic [2:0] REG_RIGHT_TOP     = 3'd5;

  // stage load enables handed from the pipeline control to the eye datapaths
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } apc_ctl_t;

  // floor(x / 1786) by reciprocal multiply, x below 1786 * 255
  function automatic logic [7:0] div_by_1786(input logic [ProdW-1:0] x);
    logic [ProdW+RecipW-1:0] prod;
    prod = {{RecipW{1'b0}}, x} * {{ProdW{1'b0}}, RECIP_1786};
    return prod[DivShift+7:DivShift];
  endfunction

endpackage

### rtl/anaglyph_pixel_combine.sv
// top level of the anaglyph pixel combiner: config registers, pipeline control, channel mux
// depends on apc_pkg and apc_eye
//
// Takes one left and one right RGB pixel per word and returns one combined pixel.
// Each eye's intensity (b + 2r + 4g) sets the black lift and white reduction of the
// other eye, then each eye's result is lift + own intensity * scale / 1786, and its low
// 8 bits go to that eye's configured channel (right wins a shared channel, a channel
// code of 3 drops the result, an unused channel reads zero). The pipeline holds six
// register stages, and one word is accepted every cycle as long as out_stall stays low;
// a stall holds each full stage whose next stage cannot load and backs up to in_stall.
// Config registers are read live and must only be written while the pipeline is empty.
module anaglyph_pixel_combine
  import apc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input pixel pair
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_left_red,
  input  logic [7:0] in_left_green,
  input  logic [7:0] in_left_blue,
  input  logic [7:0] in_right_red,
  input  logic [7:0] in_right_green,
  input  logic [7:0] in_right_blue,
  // combined pixel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  // config write port
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [1:0] left_channel_r, right_channel_r;
  logic [7:0] left_bottom_r, left_top_r, right_bottom_r, right_top_r;

  logic                  v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic                  en1, en_out;
  apc_ctl_t              ctl;
  logic [IntensityW-1:0] left_int_r, right_int_r;
  logic [IntensityW-1:0] left_int_nxt, right_int_nxt;
  logic [8:0]            left_res, right_res;
  logic [7:0]            red_r, green_r, blue_r;
  logic [7:0]            red_nxt, green_nxt, blue_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_channel_r  <= CH_RED;
      right_channel_r <= CH_GREEN;
      left_bottom_r   <= 8'd85;
      left_top_r      <= 8'd34;
      right_bottom_r  <= 8'd51;
      right_top_r     <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_CHANNEL:  left_channel_r  <= cfg_data[1:0];
        REG_RIGHT_CHANNEL: right_channel_r <= cfg_data[1:0];
        REG_LEFT_BOTTOM:   left_bottom_r   <= cfg_data;
        REG_LEFT_TOP:      left_top_r      <= cfg_data;
        REG_RIGHT_BOTTOM:  right_bottom_r  <= cfg_data;
        REG_RIGHT_TOP:     right_top_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or the next one loads
  always_comb begin
    en_out  = !out_valid_r || !out_stall;
    ctl.en5 = !v5_r || en_out;
    ctl.en4 = !v4_r || ctl.en5;
    ctl.en3 = !v3_r || ctl.en4;
    ctl.en2 = !v2_r || ctl.en3;
    en1     = !v1_r || ctl.en2;
  end

  assign in_stall = !en1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)     v1_r        <= in_valid;
      if (ctl.en2) v2_r        <= v1_r;
      if (ctl.en3) v3_r        <= v2_r;
      if (ctl.en4) v4_r        <= v3_r;
      if (ctl.en5) v5_r        <= v4_r;
      if (en_out)  out_valid_r <= v5_r;
    end
  end

  // per-eye intensity b + 2r + 4g
  always_comb begin
    left_int_nxt  = {3'b0, in_left_blue} + {2'b0, in_left_red, 1'b0}
                  + {1'b0, in_left_green, 2'b0};
    right_int_nxt = {3'b0, in_right_blue} + {2'b0, in_right_red, 1'b0}
                  + {1'b0, in_right_green, 2'b0};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      left_int_r  <= left_int_nxt;
      right_int_r <= right_int_nxt;
    end
  end

  // left eye levels follow right intensity and the other way round
  apc_eye u_left (
    .clk        (clk),
    .ctl        (ctl),
    .own_int    (left_int_r),
    .other_int  (right_int_r),
    .bottom_lvl (left_bottom_r),
    .top_lvl    (left_top_r),
    .result     (left_res)
  );

  apc_eye u_right (
    .clk        (clk),
    .ctl        (ctl),
    .own_int    (right_int_r),
    .other_int  (left_int_r),
    .bottom_lvl (right_bottom_r),
    .top_lvl    (right_top_r),
    .result     (right_res)
  );

  // channel placement, right written after left
  always_comb begin
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    unique case (left_channel_r)
      CH_RED:   red_nxt   = left_res[7:0];
      CH_GREEN: green_nxt = left_res[7:0];
      CH_BLUE:  blue_nxt  = left_res[7:0];
      default: ;
    endcase
    unique case (right_channel_r)
      CH_RED:   red_nxt   = right_res[7:0];
      CH_GREEN: green_nxt = right_res[7:0];
      CH_BLUE:  blue_nxt  = right_res[7:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

### rtl/apc_eye.sv
// one eye's level adjust datapath, four register stages
// depends on apc_pkg; instantiated twice by anaglyph_pixel_combine
module apc_eye
  import apc_pkg::*;
(
  input  logic                  clk,
  input  apc_ctl_t              ctl,
  input  logic [IntensityW-1:0] own_int,
  input  logic [IntensityW-1:0] other_int,
  input  logic [7:0]            bottom_lvl,
  input  logic [7:0]            top_lvl,
  output logic [8:0]            result
);

  logic [ProdW-1:0]      lift_prod_r, lift_prod_nxt;
  logic [ProdW-1:0]      top_prod_r, top_prod_nxt;
  logic [IntensityW-1:0] own_s2_r, own_s3_r;
  logic [7:0]            lift_s3_r, lift_s4_r, lift_s5_r;
  logic [7:0]            top_q_s3_r;
  logic [7:0]            scale_nxt;
  logic [ProdW-1:0]      res_prod_r, res_prod_nxt;
  logic [7:0]            res_q_r;

  // products feeding the black lift and white reduction
  always_comb begin
    lift_prod_nxt = {8'b0, MAX_INTENSITY - other_int} * {{(ProdW-8){1'b0}}, bottom_lvl};
    top_prod_nxt  = {8'b0, other_int} * {{(ProdW-8){1'b0}}, top_lvl};
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      lift_prod_r <= lift_prod_nxt;
      top_prod_r  <= top_prod_nxt;
      own_s2_r    <= own_int;
    end
  end

  // divide both by 1786
  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      lift_s3_r  <= div_by_1786(lift_prod_r);
      top_q_s3_r <= div_by_1786(top_prod_r);
      own_s3_r   <= own_s2_r;
    end
  end

  // scale never drops below one, so the subtraction stays in range
  always_comb begin
    scale_nxt    = FULL_LEVEL - top_q_s3_r - lift_s3_r;
    res_prod_nxt = {8'b0, own_s3_r} * {{(ProdW-8){1'b0}}, scale_nxt};
  end

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      res_prod_r <= res_prod_nxt;
      lift_s4_r  <= lift_s3_r;
    end
  end

  // scaled own intensity
  always_ff @(posedge clk) begin
    if (ctl.en5) begin
      res_q_r   <= div_by_1786(res_prod_r);
      lift_s5_r <= lift_s4_r;
    end
  end

  assign result = {1'b0, lift_s5_r} + {1'b0, res_q_r};

endmodule

### bench/anaglyph_pixel_combine_tb.sv
// self-checking bench for anaglyph_pixel_combine: predicts every combined pixel and
// compares it with each word on the result channel, under random idling and stalls
// depends on apc_pkg and the rtl of anaglyph_pixel_combine
module anaglyph_pixel_combine_tb;
  import apc_pkg::*;

  localparam int FullIntensity = 1785;
  localparam int Divisor       = 1786;
  localparam int WhiteLevel    = 255;
  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 12;
  localparam int PhaseItems    = 200;
  localparam int RandomPhases  = 6;

  // channel code that routes an eye nowhere
  localparam logic [1:0] CH_NONE = 2'd3;
  // indexes past the last register, writes there are ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0] left_red;
    logic [7:0] left_green;
    logic [7:0] left_blue;
    logic [7:0] right_red;
    logic [7:0] right_green;
    logic [7:0] right_blue;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0] left_ch;
    logic [1:0] right_ch;
    logic [7:0] left_bottom;
    logic [7:0] left_top;
    logic [7:0] right_bottom;
    logic [7:0] right_top;
  } combine_cfg_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_left_red, in_left_green, in_left_blue;
  logic [7:0] in_right_red, in_right_green, in_right_blue;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  combine_cfg_t live_cfg;
  rgb_t         pending_pixels[$];
  int           errors;
  int           pairs_sent;
  int           pixels_checked;
  int           settings_used;
  int           cycle_count;
  int           burst_left;
  int           gap_pct;
  int           stall_pct;
  int           stall_len;
  int           stall_hold;

  anaglyph_pixel_combine u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_red    (in_left_red),
    .in_left_green  (in_left_green),
    .in_left_blue   (in_left_blue),
    .in_right_red   (in_right_red),
    .in_right_green (in_right_green),
    .in_right_blue  (in_right_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // combined pixel for one pixel pair under the given settings
  function automatic rgb_t combine_pixel(pixel_pair_t w, combine_cfg_t c);
    int              li, ri;
    int              l_lift, r_lift, l_scale, r_scale, l_res, r_res;
    logic [2:0][7:0] chan;
    rgb_t            pix;
    li = int'(w.left_blue) + 2 * int'(w.left_red) + 4 * int'(w.left_green);
    ri = int'(w.right_blue) + 2 * int'(w.right_red) + 4 * int'(w.right_green);
    // each eye's black lift and white cut come from the other eye's intensity
    r_lift  = (FullIntensity - li) * int'(c.right_bottom) / Divisor;
    l_lift  = (FullIntensity - ri) * int'(c.left_bottom) / Divisor;
    r_scale = WhiteLevel - li * int'(c.right_top) / Divisor - r_lift;
    l_scale = WhiteLevel - ri * int'(c.left_top) / Divisor - l_lift;
    l_res   = l_lift + li * l_scale / Divisor;
    r_res   = r_lift + ri * r_scale / Divisor;
    // right eye goes last so it wins a shared channel
    chan = '0;
    if (c.left_ch != CH_NONE) chan[c.left_ch] = l_res[7:0];
    if (c.right_ch != CH_NONE) chan[c.right_ch] = r_res[7:0];
    pix.red   = chan[CH_RED];
    pix.green = chan[CH_GREEN];
    pix.blue  = chan[CH_BLUE];
    return pix;
  endfunction

  function automatic combine_cfg_t reset_settings();
    combine_cfg_t c;
    c.left_ch      = CH_RED;
    c.right_ch     = CH_GREEN;
    c.left_bottom  = 8'd85;
    c.left_top     = 8'd34;
    c.right_bottom = 8'd51;
    c.right_top    = 8'd0;
    return c;
  endfunction

  function automatic logic [5:0][7:0] raw_settings(logic [7:0] lc, logic [7:0] rc,
      logic [7:0] lb, logic [7:0] lt, logic [7:0] rb, logic [7:0] rt);
    logic [5:0][7:0] raw;
    raw[REG_LEFT_CHANNEL]  = lc;
    raw[REG_RIGHT_CHANNEL] = rc;
    raw[REG_LEFT_BOTTOM]   = lb;
    raw[REG_LEFT_TOP]      = lt;
    raw[REG_RIGHT_BOTTOM]  = rb;
    raw[REG_RIGHT_TOP]     = rt;
    return raw;
  endfunction

  function automatic pixel_pair_t make_pair(logic [7:0] lr, logic [7:0] lg, logic [7:0] lb,
      logic [7:0] rr, logic [7:0] rg, logic [7:0] rb);
    pixel_pair_t w;
    w.left_red    = lr;
    w.left_green  = lg;
    w.left_blue   = lb;
    w.right_red   = rr;
    w.right_green = rg;
    w.right_blue  = rb;
    return w;
  endfunction

  // mostly random bytes, with a bias toward the ends of the range
  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // cycle budget
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
               pending_pixels.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
      stall_hold = $urandom_range(0, stall_len);
    end
  end

  // compare each accepted result word with the oldest pending pixel
  always @(posedge clk) begin
    rgb_t got, want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_red, out_green, out_blue};
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  // one register write, mirrored into the local copy of the settings
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LEFT_CHANNEL:  live_cfg.left_ch      = data[1:0];
      REG_RIGHT_CHANNEL: live_cfg.right_ch     = data[1:0];
      REG_LEFT_BOTTOM:   live_cfg.left_bottom  = data;
      REG_LEFT_TOP:      live_cfg.left_top     = data;
      REG_RIGHT_BOTTOM:  live_cfg.right_bottom = data;
      REG_RIGHT_TOP:     live_cfg.right_top    = data;
      default: ;
    endcase
  endtask

  // all six registers plus one write to a spare index, pipeline must be empty
  task automatic apply_settings(input logic [5:0][7:0] raw, input logic [7:0] spare_data);
    for (int i = 0; i < 6; i++) write_reg(i[2:0], raw[i]);
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, spare_data);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // send one pixel pair, with a chance of a random gap at the start of each burst
  task automatic send_pair(input pixel_pair_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_left_red    <= w.left_red;
    in_left_green  <= w.left_green;
    in_left_blue   <= w.left_blue;
    in_right_red   <= w.right_red;
    in_right_green <= w.right_green;
    in_right_blue  <= w.right_blue;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_pixels.push_back(combine_pixel(w, live_cfg));
    pairs_sent++;
  endtask

  // stop sending and wait for every pending pixel to come back
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic send_corner_pairs();
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
  endtask

  // settings straight out of reset, no register written
  task automatic test_reset_settings();
    gap_pct   = 30;
    stall_pct = 30;
    stall_len = 4;
    send_corner_pairs();
    send_pair(make_pair(8'd200, 8'd17, 8'd99, 8'd3, 8'd140, 8'd250));
    wait_drained();
  endtask

  // bottom and top levels at both ends of their range
  task automatic test_level_extremes();
    apply_settings(raw_settings({6'd0, CH_BLUE}, {6'd0, CH_RED},
                                8'd255, 8'd255, 8'd255, 8'd255), 8'hFF);
    send_corner_pairs();
    wait_drained();
    apply_settings(raw_settings({6'd0, CH_GREEN}, {6'd0, CH_BLUE},
                                8'd0, 8'd0, 8'd0, 8'd0), 8'h00);
    send_corner_pairs();
    wait_drained();
  endtask

  // shared channel, and eyes routed nowhere with code three
  task automatic test_channel_routing();
    apply_settings(raw_settings({6'd0, CH_RED}, {6'd0, CH_RED},
                                8'd85, 8'd34, 8'd51, 8'd0), 8'h5A);
    send_pair(make_pair(8'd10, 8'd200, 8'd30, 8'd240, 8'd5, 8'd128));
    send_pair(make_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    wait_drained();
    apply_settings(raw_settings({6'd0, CH_NONE}, {6'd0, CH_BLUE},
                                8'd128, 8'd64, 8'd32, 8'd16), 8'hA5);
    send_pair(make_pair(8'd77, 8'd88, 8'd99, 8'd11, 8'd22, 8'd33));
    send_pair(make_pair(8'd1, 8'd2, 8'd3, 8'd254, 8'd253, 8'd252));
    wait_drained();
    apply_settings(raw_settings({6'd0, CH_NONE}, {6'd0, CH_NONE},
                                8'd200, 8'd100, 8'd50, 8'd25), 8'h3C);
    send_pair(make_pair(8'd128, 8'd128, 8'd128, 8'd64, 8'd64, 8'd64));
    wait_drained();
  endtask

  // upper bits of channel data are dropped, spare index writes change nothing
  task automatic test_register_decode();
    apply_settings(raw_settings(8'hFE, 8'hFD, 8'd170, 8'd85, 8'd240, 8'd15), 8'hFF);
    send_pair(make_pair(8'd90, 8'd180, 8'd45, 8'd135, 8'd225, 8'd60));
    send_pair(make_pair(8'd255, 8'd128, 8'd0, 8'd0, 8'd128, 8'd255));
    wait_drained();
  endtask

  // random pixel streams over random settings and idling patterns
  task automatic test_random_streams();
    for (int phase = 0; phase < RandomPhases; phase++) begin
      apply_settings(raw_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  random_level(), random_level(),
                                  random_level(), random_level()),
                     8'($urandom_range(0, 255)));
      if (phase == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
        stall_len = 0;
      end else begin
        gap_pct   = $urandom_range(10, 70);
        stall_pct = $urandom_range(0, 60);
        stall_len = $urandom_range(0, 12);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // one full drain in the middle of a stream
        if (phase == 3 && n == PhaseItems / 2) wait_drained();
        send_pair(make_pair(random_byte(), random_byte(), random_byte(),
                            random_byte(), random_byte(), random_byte()));
      end
      wait_drained();
    end
  endtask

  initial begin
    errors         = 0;
    pairs_sent     = 0;
    pixels_checked = 0;
    settings_used  = 0;
    cycle_count    = 0;
    burst_left     = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    stall_len      = 0;
    stall_hold     = 0;
    live_cfg       = reset_settings();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_left_red    <= 8'd0;
    in_left_green  <= 8'd0;
    in_left_blue   <= 8'd0;
    in_right_red   <= 8'd0;
    in_right_green <= 8'd0;
    in_right_blue  <= 8'd0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_LEFT_CHANNEL;
    cfg_data       <= 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_level_extremes();
    test_channel_routing();
    test_register_decode();
    test_random_streams();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d pixels never came back", $time, pending_pixels.size());
    end
    $display("sent %0d pixel pairs under %0d register settings, checked %0d results",
             pairs_sent, settings_used, pixels_checked);
    $display("covered reset values, level extremes, shared and dropped channels, spare writes");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/apc_pkg.sv
rtl/apc_eye.sv
rtl/anaglyph_pixel_combine.sv
bench/anaglyph_pixel_combine_tb.sv
